// ===== hdl/udf_pkg.sv =====
// ----------------------------------------------------------------------------
// udf_pkg
// Shared types and constants of the unsigned decimal formatter.
// ----------------------------------------------------------------------------
package udf_pkg;

  localparam int VALUE_W       = 64;
  localparam int CNT_W         = 7;   // holds any count up to 64
  localparam int NUM_DIGITS    = 20;  // decimal digits of a 64-bit value
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BITS_PER_STEP = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MAX_FIELD_DEF = 64;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] LM_NONE = 3'd0;
  localparam logic [2:0] LM_HH   = 3'd1;
  localparam logic [2:0] LM_H    = 3'd2;

  // One classified conversion request
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               has_prec;
    logic [CNT_W-1:0]   prec;
    logic [CNT_W-1:0]   width;
    logic               left;
    logic               zpad;
  } udf_cmd_t;

endpackage

// ===== hdl/udf_front.sv =====
// ----------------------------------------------------------------------------
// udf_front
// Accept side: truncates the value, saturates width and precision and hands
// the classified request to the queue.
// ----------------------------------------------------------------------------
module udf_front import udf_pkg::*; #(
  parameter int MaxField = MAX_FIELD_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [2:0]         in_length_mod,
  input  logic [6:0]         in_field_width,
  input  logic signed [7:0]  in_precision,
  input  logic               in_left_justify,
  input  logic               in_zero_pad,
  output logic               push_valid,
  input  logic               push_full,
  output udf_cmd_t           push_cmd
);

  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MaxField);

  logic [VALUE_W-1:0] value_trunc;
  logic               has_prec;

  assign has_prec   = ~in_precision[7];
  assign push_valid = in_valid;
  assign in_stall   = push_full;

  always_comb begin
    case (in_length_mod)
      LM_NONE: value_trunc = {32'd0, in_value[31:0]};
      LM_HH:   value_trunc = {56'd0, in_value[7:0]};
      LM_H:    value_trunc = {48'd0, in_value[15:0]};
      default: value_trunc = in_value;
    endcase
  end

  always_comb begin
    push_cmd.value    = value_trunc;
    push_cmd.has_prec = has_prec;
    if (!has_prec) begin
      push_cmd.prec = '0;
    end else if (CNT_W'(in_precision[6:0]) > MAX_C) begin
      push_cmd.prec = MAX_C;
    end else begin
      push_cmd.prec = CNT_W'(in_precision[6:0]);
    end
    push_cmd.width = (CNT_W'(in_field_width) > MAX_C) ? MAX_C : CNT_W'(in_field_width);
    push_cmd.left  = in_left_justify;
    push_cmd.zpad  = in_zero_pad;
  end

endmodule

// ===== hdl/udf_queue.sv =====
// ----------------------------------------------------------------------------
// udf_queue
// Short request queue between the accept side and the conversion engine.
// ----------------------------------------------------------------------------
module udf_queue import udf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_full,
  input  udf_cmd_t push_cmd,
  output logic     pop_valid,
  input  logic     pop_take,
  output udf_cmd_t pop_cmd
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_C = NW'(QUEUE_DEPTH);

  udf_cmd_t        slot_r [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_full = (count_r == DEPTH_C);
  assign pop_valid = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push_valid && !push_full;
  assign do_pop    = pop_take && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/udf_back.sv =====
// ----------------------------------------------------------------------------
// udf_back
// Conversion engine: shift-and-add-3 binary to BCD, field sizing and
// character emission through an output register.
// ----------------------------------------------------------------------------
module udf_back import udf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_take,
  input  udf_cmd_t   pop_cmd,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       out_is_last
);

  localparam int STEPS = VALUE_W / BITS_PER_STEP;
  localparam int SW    = $clog2(STEPS);
  localparam int DW    = $clog2(NUM_DIGITS);
  localparam logic [SW-1:0]    LAST_STEP = SW'(STEPS - 1);
  localparam logic [CNT_W-1:0] NDIG_C    = CNT_W'(NUM_DIGITS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_LEN  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b, input logic bin);
    logic [BCD_W-1:0] r;
    logic [3:0]       d;
    r = b;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      d = b[k*4 +: 4];
      r[k*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return {r[BCD_W-2:0], bin};
  endfunction

  logic [2:0]         state_r, state_nxt;
  udf_cmd_t           cmd_r;
  logic [VALUE_W-1:0] bin_r;
  logic [BCD_W-1:0]   bcd_r;
  logic [SW-1:0]      step_r;
  logic [CNT_W-1:0]   body_r, total_r, pad_r, idx_r;
  logic               out_valid_r;
  logic [7:0]         out_char_r;
  logic               out_is_last_r;

  logic [3:0]         digit [NUM_DIGITS];
  logic [CNT_W-1:0]   ndig;
  logic               all_zero;
  logic [CNT_W-1:0]   body_calc, total_calc;
  logic               out_free, emit;
  logic               in_body;
  logic [CNT_W-1:0]   dpos;
  logic [7:0]         char_calc, pad_char;
  logic               last_calc;

  assign pop_take    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_char    = out_char_r;
  assign out_is_last = out_is_last_r;
  assign out_free    = !out_valid_r || !out_stall;
  assign emit        = (state_r == ST_EMIT) && out_free;

  // Digit count: position of the highest non-zero digit
  always_comb begin
    all_zero = 1'b1;
    ndig     = CNT_W'(1);
    for (int k = 0; k < NUM_DIGITS; k++) begin
      digit[k] = bcd_r[k*4 +: 4];
      if (digit[k] != 4'd0) begin
        ndig     = CNT_W'(k + 1);
        all_zero = 1'b0;
      end
    end
    if (all_zero && cmd_r.has_prec && cmd_r.prec == '0) begin
      ndig = '0;
    end
    body_calc = (cmd_r.has_prec && cmd_r.prec > ndig) ? cmd_r.prec : ndig;
    // Width and precision are already saturated, so the total cannot exceed the cap
    total_calc = (cmd_r.width > body_r) ? cmd_r.width : body_r;
  end

  // Character at the current position
  always_comb begin
    pad_char = (cmd_r.zpad && !cmd_r.has_prec) ? CHAR_ZERO : CHAR_SPACE;
    if (cmd_r.left) begin
      in_body = idx_r < body_r;
      dpos    = body_r - CNT_W'(1) - idx_r;
    end else begin
      in_body = idx_r >= pad_r;
      dpos    = total_r - CNT_W'(1) - idx_r;
    end
    if (!in_body) begin
      char_calc = cmd_r.left ? CHAR_SPACE : pad_char;
    end else if (dpos < NDIG_C) begin
      char_calc = CHAR_ZERO | {4'd0, digit[dpos[DW-1:0]]};
    end else begin
      char_calc = CHAR_ZERO;
    end
    last_calc = (idx_r == total_r - CNT_W'(1));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (pop_valid) state_nxt = ST_CONV;
      ST_CONV: if (step_r == LAST_STEP) state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_LEN;
      ST_LEN:  state_nxt = (total_calc == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (emit && last_calc) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmd_r  <= pop_cmd;
        bin_r  <= pop_cmd.value;
        bcd_r  <= '0;
        step_r <= '0;
      end
      ST_CONV: begin
        bcd_r  <= dabble(dabble(bcd_r, bin_r[VALUE_W-1]), bin_r[VALUE_W-2]);
        bin_r  <= {bin_r[VALUE_W-3:0], 2'b00};
        step_r <= step_r + 1'b1;
      end
      ST_SIZE: begin
        body_r <= body_calc;
      end
      ST_LEN: begin
        total_r <= total_calc;
        pad_r   <= total_calc - body_r;
        idx_r   <= '0;
      end
      ST_EMIT: begin
        if (emit) begin
          out_char_r    <= char_calc;
          out_is_last_r <= last_calc;
          idx_r         <= idx_r + 1'b1;
        end
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

endmodule

// ===== hdl/unsigned_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// unsigned_decimal_formatter
// printf %u style conversion of one unsigned value into an ASCII field.
// ----------------------------------------------------------------------------
// Each input item carries a value, a length modifier, a minimum field width,
// a precision (negative for none) and the left-justify and zero-pad flags.
// The block returns the field one character per output item, left to right,
// and marks the final character with out_is_last; a zero value with
// precision zero and width zero yields no output at all. Width and precision
// saturate at MaxField, so a field never exceeds MaxField characters.
// In the conversion engine an item is first fetched from the queue, then
// converted by shift-and-add-3 binary to BCD at two bits a cycle, sized in
// the SIZE and LEN states, and then emitted at one character per cycle while
// the output is not stalled. A two-entry request queue sits between the
// accept side and the engine, so up to two further items are taken while
// one is being converted or emitted.
// ----------------------------------------------------------------------------
module unsigned_decimal_formatter import udf_pkg::*; #(
  parameter int MaxField = MAX_FIELD_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [2:0]         in_length_mod,
  input  logic [6:0]         in_field_width,
  input  logic signed [7:0]  in_precision,
  input  logic               in_left_justify,
  input  logic               in_zero_pad,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_is_last
);

  // Classified item from the front to the queue
  logic     push_valid;
  logic     push_full;
  udf_cmd_t push_cmd;

  // Queue head towards the conversion engine
  logic     pop_valid;
  logic     pop_take;
  udf_cmd_t pop_cmd;

  // Front: truncate the value to its length, saturate width and precision
  udf_front #(
    .MaxField (MaxField)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_length_mod   (in_length_mod),
    .in_field_width  (in_field_width),
    .in_precision    (in_precision),
    .in_left_justify (in_left_justify),
    .in_zero_pad     (in_zero_pad),
    .push_valid      (push_valid),
    .push_full       (push_full),
    .push_cmd        (push_cmd)
  );

  // Queue: hold classified items while the engine is busy
  udf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_take   (pop_take),
    .pop_cmd    (pop_cmd)
  );

  // Back: convert to BCD, size the field and emit its characters
  udf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_take    (pop_take),
    .pop_cmd     (pop_cmd),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_is_last (out_is_last)
  );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the unsigned decimal formatter.
// ----------------------------------------------------------------------------
// Feeds %u conversion requests through the input channel. Each accepted
// request is formatted by a local model into the characters of its field,
// and the checker compares every output item against the oldest pending
// character. A directed run covers the edges of each field. Three random
// phases follow, each with a different balance of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import udf_pkg::*;

  localparam int MAX_FIELD = MAX_FIELD_DEF;

  // Length modifier codes beyond the ones the package names
  localparam logic [2:0] LM_L      = 3'd3;
  localparam logic [2:0] LM_LL     = 3'd4;
  localparam logic [2:0] LM_J      = 3'd5;
  localparam logic [2:0] LM_Z      = 3'd6;
  localparam logic [2:0] LM_UNUSED = 3'd7;

  localparam logic signed [7:0] NO_PREC = -8'sd1;

  localparam int ITEMS_PER_PHASE = 52;
  localparam int DRAIN_LIMIT     = 200000;  // cycles to wait for the last field
  localparam int SETTLE_CYCLES   = 150;     // covers one full-width item in the engine

  // One conversion request as it appears on the input ports
  typedef struct {
    logic [63:0]       value;
    logic [2:0]        lm;
    logic [6:0]        width;
    logic signed [7:0] prec;
    logic              left;
    logic              zpad;
  } fmt_req_t;

  // One character still owed by the block
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [63:0]       in_value;
  logic [2:0]        in_length_mod;
  logic [6:0]        in_field_width;
  logic signed [7:0] in_precision;
  logic              in_left_justify;
  logic              in_zero_pad;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        out_char;
  logic              out_is_last;

  field_char_t pending_chars[$];
  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;

  unsigned_decimal_formatter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_value        (in_value),
    .in_length_mod   (in_length_mod),
    .in_field_width  (in_field_width),
    .in_precision    (in_precision),
    .in_left_justify (in_left_justify),
    .in_zero_pad     (in_zero_pad),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char        (out_char),
    .out_is_last     (out_is_last)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Work out the characters of one field and queue them, left to right.
  // Truncate the value by its length modifier, saturate width and precision,
  // count the digits, then lay out padding and zero-extended digits.
  function automatic void format_field(fmt_req_t r);
    logic [63:0] n;
    logic [63:0] t;
    logic [7:0]  chars[MAX_FIELD];
    logic [7:0]  pad_ch;
    bit          has_prec;
    int          width;
    int          prec;
    int          ndig;
    int          body;
    int          total;
    int          pad;
    int          digit_base;
    field_char_t fc;

    case (r.lm)
      LM_NONE: n = {32'b0, r.value[31:0]};
      LM_HH:   n = {56'b0, r.value[7:0]};
      LM_H:    n = {48'b0, r.value[15:0]};
      default: n = r.value;  // l, ll, j, z and the unused code keep 64 bits
    endcase

    width    = (r.width > MAX_FIELD) ? MAX_FIELD : int'(r.width);
    has_prec = !r.prec[7];   // any negative precision means none was given
    prec     = has_prec ? int'(r.prec[6:0]) : 0;
    if (prec > MAX_FIELD) prec = MAX_FIELD;

    // A zero value with precision zero has no digits at all
    ndig = (has_prec && prec == 0 && n == 0) ? 0 : 1;
    t = n / 10;
    while (t != 0) begin
      ndig++;
      t = t / 10;
    end

    body  = (has_prec && prec > ndig) ? prec : ndig;
    total = (width > body) ? width : body;
    if (total > MAX_FIELD) total = MAX_FIELD;
    if (body > total) body = total;
    pad = total - body;

    // Left justify wins over zero pad; a precision suppresses zero pad
    if (r.left) begin
      digit_base = 0;
      for (int i = body; i < total; i++) chars[i] = CHAR_SPACE;
    end else begin
      pad_ch = (r.zpad && !has_prec) ? CHAR_ZERO : CHAR_SPACE;
      digit_base = pad;
      for (int i = 0; i < pad; i++) chars[i] = pad_ch;
    end

    t = n;
    for (int i = body - 1; i >= 0; i--) begin
      chars[digit_base + i] = CHAR_ZERO + 8'(t % 10);
      t = t / 10;
    end

    for (int i = 0; i < total; i++) begin
      fc.ch   = chars[i];
      fc.last = (i == total - 1);
      pending_chars.push_back(fc);
    end
  endfunction

  function automatic fmt_req_t mk_req(logic [63:0] value, logic [2:0] lm, logic [6:0] width,
                                      logic signed [7:0] prec, logic left, logic zpad);
    fmt_req_t r;
    r.value = value;
    r.lm    = lm;
    r.width = width;
    r.prec  = prec;
    r.left  = left;
    r.zpad  = zpad;
    return r;
  endfunction

  // Random request: values of every digit count, mostly short fields,
  // now and then an oversized width or precision.
  function automatic fmt_req_t random_req();
    fmt_req_t r;
    case ($urandom_range(0, 9))
      0:       r.value = '0;
      1:       r.value = '1;
      default: r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    r.lm    = 3'($urandom_range(0, 7));
    r.width = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 24));
    case ($urandom_range(0, 9))
      0, 1, 2: r.prec = NO_PREC;
      3:       r.prec = {1'b1, 7'($urandom)};          // some other negative value
      4:       r.prec = 8'($urandom_range(0, 127));    // may saturate
      default: r.prec = 8'($urandom_range(0, 24));
    endcase
    r.left = 1'($urandom);
    r.zpad = 1'($urandom);
    return r;
  endfunction

  // Send one item. Enter and leave just after a falling edge; idle for a
  // random number of cycles first, then hold the item until it is taken.
  task automatic send_item(fmt_req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_value        <= r.value;
    in_length_mod   <= r.lm;
    in_field_width  <= r.width;
    in_precision    <= r.prec;
    in_left_justify <= r.left;
    in_zero_pad     <= r.zpad;
    do @(posedge clk); while (in_stall);
    format_field(r);
    @(negedge clk);
  endtask

  // Receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end
  end

  // Check every accepted output item against the oldest pending character
  always @(posedge clk) begin
    field_char_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected output item: char %h last %b", $time, out_char,
                 out_is_last);
        error_count++;
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_char !== exp_c.ch) begin
          $display("%0t: out_char mismatch: expected %h actual %h", $time, exp_c.ch,
                   out_char);
          error_count++;
        end
        if (out_is_last !== exp_c.last) begin
          $display("%0t: out_is_last mismatch: expected %b actual %b", $time,
                   exp_c.last, out_is_last);
          error_count++;
        end
      end
    end
  end

  // Edges of every field: each length modifier, the empty field, saturation,
  // the interplay of the two flags and precision, and full-width values.
  task automatic test_directed();
    send_item(mk_req(64'd0, LM_LL, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req(64'd0, LM_LL, 7'd0, 8'sd0, 1'b0, 1'b0));      // empty field, no items
    send_item(mk_req(64'd0, LM_NONE, 7'd5, 8'sd0, 1'b0, 1'b1));    // no digits, all padding
    send_item(mk_req('1, LM_NONE, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_HH, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_H, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_L, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_LL, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_J, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_Z, 7'd0, NO_PREC, 1'b0, 1'b0));
    send_item(mk_req('1, LM_UNUSED, 7'd0, NO_PREC, 1'b0, 1'b0));  // unused code keeps 64 bits
    send_item(mk_req(64'd42, LM_NONE, 7'd127, NO_PREC, 1'b0, 1'b0)); // width saturates
    send_item(mk_req(64'd42, LM_NONE, 7'd0, 8'sd127, 1'b0, 1'b0));   // precision saturates
    send_item(mk_req('1, LM_LL, 7'd64, 8'sd64, 1'b0, 1'b1));
    send_item(mk_req(64'd42, LM_NONE, 7'd10, NO_PREC, 1'b0, 1'b1));  // zero padding
    send_item(mk_req(64'd42, LM_NONE, 7'd10, 8'sd5, 1'b0, 1'b1));    // precision beats zero pad
    send_item(mk_req(64'd42, LM_NONE, 7'd10, NO_PREC, 1'b1, 1'b1));  // left beats zero pad
    send_item(mk_req(64'd42, LM_NONE, 7'd10, -8'sd128, 1'b0, 1'b1)); // other negative precision
    send_item(mk_req(64'd42, LM_NONE, 7'd10, NO_PREC, 1'b1, 1'b0));
    send_item(mk_req(64'd12345, LM_NONE, 7'd3, 8'sd2, 1'b0, 1'b0));  // body wider than field
    send_item(mk_req(64'd1, LM_LL, 7'd30, 8'sd25, 1'b1, 1'b0));
    send_item(mk_req('1, LM_UNUSED, 7'd127, 8'sd127, 1'b1, 1'b1));
    send_item(mk_req(64'd0, LM_NONE, 7'd0, 8'sd0, 1'b1, 1'b1));      // empty field, flags set
  endtask

  task automatic run_random(int count);
    repeat (count) send_item(random_req());
  endtask

  // Slow receiver: output stalls pile up behind the request queue
  task automatic test_slow_receiver();
    sender_idle_pct    = 23;
    receiver_stall_pct = 87;
    run_random(ITEMS_PER_PHASE);
  endtask

  // Slow sender: the engine runs dry between items
  task automatic test_slow_sender();
    sender_idle_pct    = 87;
    receiver_stall_pct = 23;
    run_random(ITEMS_PER_PHASE);
  endtask

  // Back to back on both sides
  task automatic test_streaming();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    run_random(ITEMS_PER_PHASE);
  endtask

  initial begin
    int waited;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_value        = '0;
    in_length_mod   = '0;
    in_field_width  = '0;
    in_precision    = '0;
    in_left_justify = 1'b0;
    in_zero_pad     = 1'b0;
    waited          = 0;

    // Hold reset, then release it on a falling edge
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct    = 23;
    receiver_stall_pct = 87;
    test_directed();
    test_slow_receiver();
    test_slow_sender();
    test_streaming();
    in_valid <= 1'b0;

    // Drain the last fields, then watch for stray output items
    while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d characters never arrived", $time, pending_chars.size());
      error_count++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("%0t: run timed out", $time);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
